>>> hdl/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg: shared types, codes and CRC function for the Modbus RTU framer
// Holds the item structs of both channels, the command word passed from the
// front end to the byte sequencer, and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package mrtu_pkg;

    // Request modes carried in the mode field
    localparam logic [2:0] MODE_WRITE_SINGLE = 3'd0;
    localparam logic [2:0] MODE_READ_HOLDING = 3'd1;
    localparam logic [2:0] MODE_GRIP_CMD     = 3'd2;
    localparam logic [2:0] MODE_POS_READ     = 3'd3;
    localparam logic [2:0] MODE_RX_BYTE      = 3'd4;

    // Modbus function codes
    localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
    localparam logic [7:0] FN_READ_HOLDING = 8'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SLAVE_ID      = 3'd0;
    localparam logic [2:0] CFG_GRIP_ADDR     = 3'd1;
    localparam logic [2:0] CFG_SPEED_CODE    = 3'd2;
    localparam logic [2:0] CFG_POSITION_ADDR = 3'd3;
    localparam logic [2:0] CFG_CRC_LOW_FIRST = 3'd4;

    // Result kinds
    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] READ_COUNT  = 16'd1;
    localparam logic [7:0]  SLAVE_RESET = 8'd1;

    // Response byte positions
    localparam logic [2:0] RX_VAL_HI   = 3'd3;
    localparam logic [2:0] RX_VAL_LO   = 3'd4;
    localparam logic [2:0] RX_CRC_1ST  = 3'd5;
    localparam logic [2:0] RX_CRC_2ND  = 3'd6;

    // Request frame byte positions
    localparam logic [2:0] TX_SLAVE    = 3'd0;
    localparam logic [2:0] TX_FN       = 3'd1;
    localparam logic [2:0] TX_ADDR_HI  = 3'd2;
    localparam logic [2:0] TX_ADDR_LO  = 3'd3;
    localparam logic [2:0] TX_DATA_HI  = 3'd4;
    localparam logic [2:0] TX_DATA_LO  = 3'd5;
    localparam logic [2:0] TX_CRC_1ST  = 3'd6;
    localparam logic [2:0] TX_CRC_2ND  = 3'd7;

    // Command queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] reg_addr;
        logic [15:0] write_value;
        logic [7:0]  rx_byte;
        logic        rx_first;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] read_value;
        logic        crc_ok;
    } out_item_t;

    typedef struct packed {
        logic        is_verdict;
        logic [7:0]  slave;
        logic [7:0]  fn;
        logic [15:0] addr;
        logic [15:0] data;
        logic        low_first;
        logic [15:0] read_value;
        logic        crc_ok;
    } cmd_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> hdl/mrtu_front.sv
// ----------------------------------------------------------------------------
// mrtu_front: item intake and classification
// Holds the configuration registers, turns request items into frame
// commands, and tracks response bytes, pushing a verdict on the seventh.
// ----------------------------------------------------------------------------
module mrtu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mrtu_pkg::in_item_t  in_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                q_full,
    output logic                push,
    output mrtu_pkg::cmd_t      push_cmd
);

    logic [7:0]  slave_id_reg;
    logic [15:0] grip_addr_reg;
    logic [3:0]  speed_code_reg;
    logic [15:0] position_addr_reg;
    logic        crc_low_first_reg;

    logic [2:0]  rx_count_reg,    rx_count_next;
    logic [15:0] rx_crc_reg,      rx_crc_next;
    logic [15:0] rx_value_reg,    rx_value_next;
    logic [7:0]  rx_first_b_reg,  rx_first_b_next;

    logic        accept;
    logic [2:0]  eff_count;
    logic [15:0] eff_crc;
    logic [15:0] eff_value;
    logic [7:0]  eff_first_b;
    logic [15:0] got_crc;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_id_reg      <= mrtu_pkg::SLAVE_RESET;
            grip_addr_reg     <= '0;
            speed_code_reg    <= '0;
            position_addr_reg <= '0;
            crc_low_first_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mrtu_pkg::CFG_SLAVE_ID:      slave_id_reg      <= cfg_data[7:0];
                mrtu_pkg::CFG_GRIP_ADDR:     grip_addr_reg     <= cfg_data;
                mrtu_pkg::CFG_SPEED_CODE:    speed_code_reg    <= cfg_data[3:0];
                mrtu_pkg::CFG_POSITION_ADDR: position_addr_reg <= cfg_data;
                mrtu_pkg::CFG_CRC_LOW_FIRST: crc_low_first_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Receive tracking; a start mark restarts the frame before this byte
    always_comb
    begin
        eff_count   = in_item.rx_first ? 3'd0 : rx_count_reg;
        eff_crc     = in_item.rx_first ? mrtu_pkg::CRC_INIT : rx_crc_reg;
        eff_value   = in_item.rx_first ? 16'd0 : rx_value_reg;
        eff_first_b = in_item.rx_first ? 8'd0 : rx_first_b_reg;

        if (crc_low_first_reg)
            got_crc = {in_item.rx_byte, eff_first_b};
        else
            got_crc = {eff_first_b, in_item.rx_byte};

        rx_count_next   = rx_count_reg;
        rx_crc_next     = rx_crc_reg;
        rx_value_next   = rx_value_reg;
        rx_first_b_next = rx_first_b_reg;

        push                = 1'b0;
        push_cmd.is_verdict = 1'b0;
        push_cmd.slave      = slave_id_reg;
        push_cmd.fn         = mrtu_pkg::FN_WRITE_SINGLE;
        push_cmd.addr       = in_item.reg_addr;
        push_cmd.data       = in_item.write_value;
        push_cmd.low_first  = crc_low_first_reg;
        push_cmd.read_value = eff_value;
        push_cmd.crc_ok     = (got_crc == eff_crc);

        case (in_item.mode)
            mrtu_pkg::MODE_WRITE_SINGLE:
            begin
                push = accept;
            end
            mrtu_pkg::MODE_READ_HOLDING:
            begin
                push          = accept;
                push_cmd.fn   = mrtu_pkg::FN_READ_HOLDING;
                push_cmd.data = mrtu_pkg::READ_COUNT;
            end
            mrtu_pkg::MODE_GRIP_CMD:
            begin
                push          = accept;
                push_cmd.addr = grip_addr_reg;
                push_cmd.data = {speed_code_reg, 12'd0} | in_item.write_value;
            end
            mrtu_pkg::MODE_POS_READ:
            begin
                push          = accept;
                push_cmd.fn   = mrtu_pkg::FN_READ_HOLDING;
                push_cmd.addr = position_addr_reg;
                push_cmd.data = mrtu_pkg::READ_COUNT;
            end
            mrtu_pkg::MODE_RX_BYTE:
            begin
                if (accept)
                begin
                    rx_count_next   = eff_count;
                    rx_crc_next     = eff_crc;
                    rx_value_next   = eff_value;
                    rx_first_b_next = eff_first_b;
                    if (eff_count <= mrtu_pkg::RX_VAL_LO)
                    begin
                        rx_crc_next   = mrtu_pkg::crc_update(eff_crc, in_item.rx_byte);
                        rx_count_next = eff_count + 3'd1;
                        if (eff_count == mrtu_pkg::RX_VAL_HI)
                            rx_value_next = {in_item.rx_byte, 8'd0};
                        else if (eff_count == mrtu_pkg::RX_VAL_LO)
                            rx_value_next = {eff_value[15:8], in_item.rx_byte};
                    end
                    else if (eff_count == mrtu_pkg::RX_CRC_1ST)
                    begin
                        rx_first_b_next = in_item.rx_byte;
                        rx_count_next   = mrtu_pkg::RX_CRC_2ND;
                    end
                    else
                    begin
                        push                = 1'b1;
                        push_cmd.is_verdict = 1'b1;
                        rx_count_next       = 3'd0;
                        rx_crc_next         = mrtu_pkg::CRC_INIT;
                        rx_value_next       = 16'd0;
                        rx_first_b_next     = 8'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg   <= '0;
            rx_crc_reg     <= mrtu_pkg::CRC_INIT;
            rx_value_reg   <= '0;
            rx_first_b_reg <= '0;
        end
        else
        begin
            rx_count_reg   <= rx_count_next;
            rx_crc_reg     <= rx_crc_next;
            rx_value_reg   <= rx_value_next;
            rx_first_b_reg <= rx_first_b_next;
        end
    end

endmodule

>>> hdl/mrtu_queue.sv
// ----------------------------------------------------------------------------
// mrtu_queue: short command queue between front end and byte sequencer
// First-word-fall-through; the head is visible while it waits to be popped.
// ----------------------------------------------------------------------------
module mrtu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mrtu_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output mrtu_pkg::cmd_t  head_cmd
);

    mrtu_pkg::cmd_t                entry_reg [mrtu_pkg::QUEUE_DEPTH];
    logic [mrtu_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [mrtu_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [mrtu_pkg::QCNT_W-1:0]   count_reg,  count_next;

    assign full       = (count_reg == mrtu_pkg::QCNT_W'(mrtu_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mrtu_pkg::QCNT_W'(mrtu_pkg::QUEUE_DEPTH))
        else $error("command queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("push into full command queue");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue count did not advance on push");

endmodule

>>> hdl/mrtu_back.sv
// ----------------------------------------------------------------------------
// mrtu_back: byte sequencer and output register
// Walks a request command through its eight frame bytes, folding each of
// the first six into the CRC, and passes verdicts through as one result.
// ----------------------------------------------------------------------------
module mrtu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  mrtu_pkg::cmd_t      head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output mrtu_pkg::out_item_t out_item
);

    logic [2:0]          idx_reg,       idx_next;
    logic [15:0]         crc_reg,       crc_next;
    logic                out_valid_reg, out_valid_next;
    mrtu_pkg::out_item_t out_reg,       out_next;

    logic       load;
    logic [7:0] cur_byte;
    logic [7:0] crc_byte;

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        if (head_cmd.low_first == (idx_reg == mrtu_pkg::TX_CRC_1ST))
            crc_byte = crc_reg[7:0];
        else
            crc_byte = crc_reg[15:8];

        case (idx_reg)
            mrtu_pkg::TX_SLAVE:   cur_byte = head_cmd.slave;
            mrtu_pkg::TX_FN:      cur_byte = head_cmd.fn;
            mrtu_pkg::TX_ADDR_HI: cur_byte = head_cmd.addr[15:8];
            mrtu_pkg::TX_ADDR_LO: cur_byte = head_cmd.addr[7:0];
            mrtu_pkg::TX_DATA_HI: cur_byte = head_cmd.data[15:8];
            mrtu_pkg::TX_DATA_LO: cur_byte = head_cmd.data[7:0];
            default:              cur_byte = crc_byte;
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_next       = out_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
            if (head_cmd.is_verdict)
            begin
                pop                 = 1'b1;
                out_next.kind       = mrtu_pkg::KIND_VERDICT;
                out_next.tx_byte    = 8'd0;
                out_next.tx_last    = 1'b0;
                out_next.read_value = head_cmd.read_value;
                out_next.crc_ok     = head_cmd.crc_ok;
            end
            else
            begin
                out_next.kind       = mrtu_pkg::KIND_TX;
                out_next.tx_byte    = cur_byte;
                out_next.tx_last    = (idx_reg == mrtu_pkg::TX_CRC_2ND);
                out_next.read_value = 16'd0;
                out_next.crc_ok     = 1'b0;
                if (idx_reg == mrtu_pkg::TX_CRC_2ND)
                begin
                    pop      = 1'b1;
                    idx_next = 3'd0;
                    crc_next = mrtu_pkg::CRC_INIT;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg <= mrtu_pkg::TX_DATA_LO)
                        crc_next = mrtu_pkg::crc_update(crc_reg, cur_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= mrtu_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_mid_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 3'd0 |-> head_valid && !head_cmd.is_verdict)
        else $error("request command left the queue mid-frame");

    a_last_on_eighth: assert property (@(posedge clk) disable iff (!rst_n)
        load && !head_cmd.is_verdict && idx_reg == mrtu_pkg::TX_CRC_2ND
        |=> out_valid_reg && out_reg.tx_last)
        else $error("final frame byte not marked last");

    a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.tx_last |-> out_reg.kind == mrtu_pkg::KIND_TX)
        else $error("last flag on a verdict result");

endmodule

>>> hdl/modbus_rtu_master_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer: Modbus RTU request framer and response checker
// Builds 8-byte request frames with CRC-16/MODBUS and checks 7-byte replies.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : request or response-byte items. Modes 0-3 each produce eight
//            transmit-byte results (slave, function, address, data, CRC);
//            mode 4 feeds one response byte, and the seventh byte of a reply
//            produces one verdict result (value from bytes 3-4, CRC match).
//            Modes 5-7 are taken and dropped.
//   out_*  : result items, one per cycle while out_ready is high.
//   cfg_*  : register writes (slave id, grip address, speed code, position
//            address, CRC byte order); always ready. The user must write
//            them only when idle; the block does not enforce this.
// Path: a taken request is written into the command queue, and the byte
//   sequencer then loads its first byte into the output register. A request
//   leaves the sequencer as eight transmit-byte results, a verdict as one;
//   the four-entry command queue keeps taking items meanwhile.
// Stall: when out_ready is low and a result waits, the output register holds,
//   the sequencer waits, and in_ready drops once the queue fills.
// Reset: clears queue, sequencer, receive tracking and loads register
//   defaults (slave id 1, all else 0).
// ----------------------------------------------------------------------------
module modbus_rtu_master_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mrtu_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mrtu_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    logic           push;
    mrtu_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           pop;
    logic           head_valid;
    mrtu_pkg::cmd_t head_cmd;

    // Front end: classify items, hold config and receive state
    mrtu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Decouple intake from byte sequencing
    mrtu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: emit frame bytes and verdicts through the output register
    mrtu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
